[hdl/fsnp_pkg.sv]
// ----------------------------------------------------------------------------
// fsnp_pkg
// Shared types and constants for the FAT 8.3 short name parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fsnp_pkg;

  localparam int unsigned BASE_BYTES = 8;
  localparam int unsigned EXT_BYTES  = 3;
  localparam int unsigned NAME_BYTES = BASE_BYTES + EXT_BYTES;

  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DOT      = 8'h2E;
  localparam logic [7:0] CHAR_SLASH    = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_DELETED  = 8'hE5;
  localparam logic [7:0] CHAR_KANJI05  = 8'h05;
  localparam logic [7:0] CHAR_LAST7BIT = 8'd127;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef enum logic [1:0] {
    PH_BASE  = 2'd0,
    PH_EXTRA = 2'd1,
    PH_EXT   = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    K_CHAR    = 2'd0,
    K_TERM    = 2'd1,
    K_ILLEGAL = 2'd2,
    K_DOT     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ILLEGAL  = 2'd1,
    STAT_BASE_LEN = 2'd2,
    STAT_EXT_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       sep;
  } class_t;

  typedef struct packed {
    logic [8*BASE_BYTES-1:0] name_base;
    logic [8*EXT_BYTES-1:0]  name_ext;
    status_t                 status;
    logic                    ended_by_separator;
  } result_t;

endpackage

`default_nettype wire

[hdl/fsnp_if.sv]
// ----------------------------------------------------------------------------
// fsnp_if
// Valid/ready channels for path bytes and finished short names.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_char;

  modport source (output valid, output path_char, input ready);
  modport sink   (input valid, input path_char, output ready);
endinterface

interface fsnp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_base;
  logic [23:0] name_ext;
  logic [1:0]  status;
  logic        ended_by_separator;

  modport source (output valid, output name_base, output name_ext, output status,
                  output ended_by_separator, input ready);
  modport sink   (input valid, input name_base, input name_ext, input status,
                  input ended_by_separator, output ready);
endinterface

`default_nettype wire

[hdl/fsnp_classify.sv]
// ----------------------------------------------------------------------------
// fsnp_classify
// Sorts one path byte into terminator, dot, illegal or a mapped name byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnp_classify (
  input  wire logic [7:0]      ch_i,
  output fsnp_pkg::class_t     cls_o
);

  always_comb begin
    cls_o.sep  = (ch_i == fsnp_pkg::CHAR_SLASH) || (ch_i == fsnp_pkg::CHAR_BSLASH);
    cls_o.ch   = ch_i;
    cls_o.kind = fsnp_pkg::K_CHAR;
    if (ch_i == fsnp_pkg::CHAR_NUL || cls_o.sep) begin
      cls_o.kind = fsnp_pkg::K_TERM;
    end else if (ch_i == fsnp_pkg::CHAR_DOT) begin
      cls_o.kind = fsnp_pkg::K_DOT;
    end else if (ch_i inside {[8'h41:8'h5A], [8'h30:8'h39]}) begin
      cls_o.kind = fsnp_pkg::K_CHAR;
    end else if (ch_i inside {[8'h61:8'h7A]}) begin
      cls_o.ch = ch_i - fsnp_pkg::CASE_OFFSET;
    end else if (ch_i == fsnp_pkg::CHAR_DELETED) begin
      cls_o.ch = fsnp_pkg::CHAR_KANJI05;
    end else if (ch_i > fsnp_pkg::CHAR_LAST7BIT) begin
      cls_o.kind = fsnp_pkg::K_CHAR;
    end else if (ch_i inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
                              8'h2D, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E,
                              8'h20}) begin
      cls_o.kind = fsnp_pkg::K_CHAR;
    end else begin
      cls_o.kind = fsnp_pkg::K_ILLEGAL;
    end
  end

endmodule

`default_nettype wire

[hdl/fsnp_core.sv]
// ----------------------------------------------------------------------------
// fsnp_core
// Component state (name bytes, position, phase) and its one-step update.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnp_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en_i,
  input  wire fsnp_pkg::class_t  cls_i,
  output logic                   res_valid_o,
  output fsnp_pkg::result_t      res_o
);

  localparam int unsigned NB = fsnp_pkg::NAME_BYTES;

  logic [7:0]       store_r   [NB];
  logic [7:0]       store_nxt [NB];
  logic [7:0]       emit_store[NB];
  logic [3:0]       pos_r, pos_nxt;
  fsnp_pkg::phase_t phase_r, phase_nxt;
  logic             dotw_r, dotw_nxt;

  logic             ok, err, clr;
  fsnp_pkg::status_t err_code;

  always_comb begin
    store_nxt  = store_r;
    emit_store = store_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    dotw_nxt   = dotw_r;
    ok         = 1'b0;
    err        = 1'b0;
    clr        = 1'b0;
    err_code   = fsnp_pkg::STAT_OK;

    case (phase_r)
      fsnp_pkg::PH_BASE: begin
        if (dotw_r) begin
          // the byte after a second dot decides: "..", the start of an extension or an error
          if (cls_i.kind == fsnp_pkg::K_TERM) begin
            emit_store[1] = fsnp_pkg::CHAR_DOT;
            ok = 1'b1;
          end else if (cls_i.kind == fsnp_pkg::K_ILLEGAL) begin
            err = 1'b1;
            err_code = fsnp_pkg::STAT_ILLEGAL;
          end else if (cls_i.kind == fsnp_pkg::K_DOT) begin
            err = 1'b1;
            err_code = fsnp_pkg::STAT_EXT_BAD;
          end else begin
            store_nxt[fsnp_pkg::BASE_BYTES] = cls_i.ch;
            pos_nxt   = 4'd1;
            phase_nxt = fsnp_pkg::PH_EXT;
            dotw_nxt  = 1'b0;
          end
        end else if (cls_i.kind == fsnp_pkg::K_TERM) begin
          ok = 1'b1;
        end else if (cls_i.kind == fsnp_pkg::K_DOT) begin
          if (pos_r == 4'd0) begin
            store_nxt[0] = fsnp_pkg::CHAR_DOT;
            pos_nxt = 4'd1;
          end else if (pos_r == 4'd1 && store_r[0] == fsnp_pkg::CHAR_DOT) begin
            dotw_nxt = 1'b1;
          end else begin
            phase_nxt = fsnp_pkg::PH_EXT;
            pos_nxt   = 4'd0;
          end
        end else if (pos_r >= 4'(fsnp_pkg::BASE_BYTES)) begin
          // one extra base byte is dropped unchecked
          phase_nxt = fsnp_pkg::PH_EXTRA;
        end else if (cls_i.kind == fsnp_pkg::K_ILLEGAL) begin
          err = 1'b1;
          err_code = fsnp_pkg::STAT_ILLEGAL;
        end else begin
          store_nxt[pos_r[2:0]] = cls_i.ch;
          pos_nxt = pos_r + 4'd1;
        end
      end
      fsnp_pkg::PH_EXTRA: begin
        if (cls_i.kind == fsnp_pkg::K_TERM) begin
          ok = 1'b1;
        end else if (cls_i.kind == fsnp_pkg::K_DOT) begin
          phase_nxt = fsnp_pkg::PH_EXT;
          pos_nxt   = 4'd0;
        end else if (cls_i.kind == fsnp_pkg::K_ILLEGAL) begin
          err = 1'b1;
          err_code = fsnp_pkg::STAT_ILLEGAL;
        end else begin
          err = 1'b1;
          err_code = fsnp_pkg::STAT_BASE_LEN;
        end
      end
      fsnp_pkg::PH_EXT: begin
        if (cls_i.kind == fsnp_pkg::K_TERM) begin
          ok = 1'b1;
        end else if (cls_i.kind == fsnp_pkg::K_ILLEGAL) begin
          err = 1'b1;
          err_code = fsnp_pkg::STAT_ILLEGAL;
        end else if (cls_i.kind == fsnp_pkg::K_DOT || pos_r >= 4'(fsnp_pkg::EXT_BYTES)) begin
          err = 1'b1;
          err_code = fsnp_pkg::STAT_EXT_BAD;
        end else begin
          store_nxt[4'(fsnp_pkg::BASE_BYTES) + {2'b00, pos_r[1:0]}] = cls_i.ch;
          pos_nxt = pos_r + 4'd1;
        end
      end
      default: begin
        // skipping after an error until the component ends
        if (cls_i.kind == fsnp_pkg::K_TERM) begin
          clr = 1'b1;
        end
      end
    endcase

    if (err) begin
      phase_nxt = fsnp_pkg::PH_SKIP;
      dotw_nxt  = 1'b0;
    end
    if (ok || clr) begin
      for (int i = 0; i < NB; i++) begin
        store_nxt[i] = fsnp_pkg::CHAR_SPACE;
      end
      pos_nxt   = 4'd0;
      phase_nxt = fsnp_pkg::PH_BASE;
      dotw_nxt  = 1'b0;
    end

    res_valid_o = ok || err;
    res_o.name_base = '0;
    res_o.name_ext  = '0;
    res_o.status    = err_code;
    res_o.ended_by_separator = 1'b0;
    if (ok) begin
      for (int i = 0; i < fsnp_pkg::BASE_BYTES; i++) begin
        res_o.name_base[8*(fsnp_pkg::BASE_BYTES-1-i) +: 8] = emit_store[i];
      end
      for (int i = 0; i < fsnp_pkg::EXT_BYTES; i++) begin
        res_o.name_ext[8*(fsnp_pkg::EXT_BYTES-1-i) +: 8] =
          emit_store[fsnp_pkg::BASE_BYTES + i];
      end
      res_o.ended_by_separator = cls_i.sep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        store_r[i] <= fsnp_pkg::CHAR_SPACE;
      end
      pos_r   <= 4'd0;
      phase_r <= fsnp_pkg::PH_BASE;
      dotw_r  <= 1'b0;
    end else if (step_en_i) begin
      store_r <= store_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      dotw_r  <= dotw_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/fat_short_name_parser_unit.sv]
// ----------------------------------------------------------------------------
// fat_short_name_parser_unit
// Turns a stream of path bytes into FAT 8.3 names, one result per component.
// ----------------------------------------------------------------------------
// path: a name reaches out_chan from its last byte through the input register,
//   then the result register
// throughput: one path byte per cycle; the input register advances whenever
//   the result register is empty or being taken
// reset: synchronous active-low rst_n empties both registers and restarts
//   the component with an all-space name
`default_nettype none

module fat_short_name_parser_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fsnp_in_if.sink     in_chan,
  fsnp_out_if.source  out_chan
);

  logic              s1_valid_r;
  logic [7:0]        s1_char_r;
  logic              s1_adv;

  logic              out_valid_r;
  fsnp_pkg::result_t out_res_r;

  fsnp_pkg::class_t  cls;
  logic              res_valid;
  fsnp_pkg::result_t res;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_char_r <= in_chan.path_char;
    end
  end

  fsnp_classify u_classify (
    .ch_i  (s1_char_r),
    .cls_o (cls)
  );

  fsnp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en_i   (s1_adv),
    .cls_i       (cls),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.name_base          = out_res_r.name_base;
  assign out_chan.name_ext           = out_res_r.name_ext;
  assign out_chan.status             = out_res_r.status;
  assign out_chan.ended_by_separator = out_res_r.ended_by_separator;

  // error results carry no name
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != fsnp_pkg::STAT_OK) |->
      (out_res_r.name_base == '0 && out_res_r.name_ext == '0 &&
       !out_res_r.ended_by_separator))
    else $error("error result with nonzero name fields");

  // an empty result register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty result register");

  // a new result only comes from a byte held in the input register
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_valid_r))
    else $error("result appeared without a byte in the input register");

endmodule

`default_nettype wire

[tb/fat_short_name_parser_unit_tb.sv]
// ----------------------------------------------------------------------------
// fat_short_name_parser_unit_tb
// Streams path bytes into the 8.3 name parser and checks every finished name
// or error report against a behavioral predictor. The run starts with short
// directed paths and continues with random components, most of them
// well-formed, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_short_name_parser_unit_tb;
  import fsnp_pkg::*;

  localparam int unsigned PATH_BYTES  = 1750;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic clk;
  logic rst_n;

  fsnp_in_if  in_chan ();
  fsnp_out_if out_chan ();

  fat_short_name_parser_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  logic [7:0]  pending_chars[$];
  result_t     expected_names[$];
  result_t     name_got;
  int unsigned queued_chars;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  bit          failed;

  // predictor state for the component being built
  logic [7:0] name_buf[0:NAME_BYTES-1];
  logic [3:0] name_pos;
  phase_t     name_phase;
  bit         dot_pending;

  function automatic class_t classify_byte(input logic [7:0] c);
    class_t k;
    k.ch   = c;
    k.sep  = (c == CHAR_SLASH) || (c == CHAR_BSLASH);
    k.kind = K_CHAR;
    if (c == CHAR_NUL || k.sep) begin
      k.kind = K_TERM;
    end else if (c == CHAR_DOT) begin
      k.kind = K_DOT;
    end else if (c >= "a" && c <= "z") begin
      k.ch = c - CASE_OFFSET;
    end else if (c == CHAR_DELETED) begin
      k.ch = CHAR_KANJI05;
    end else if (c > CHAR_LAST7BIT || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
      // passes unchanged
    end else begin
      case (c)
        "!", "#", "$", "%", "&", "'", "(", ")", "-", "@", "^", "_",
        8'h60, "{", "}", "~", " ": k.kind = K_CHAR;
        default: k.kind = K_ILLEGAL;
      endcase
    end
    return k;
  endfunction

  function automatic void restart_name();
    for (int i = 0; i < NAME_BYTES; i++) name_buf[i] = CHAR_SPACE;
    name_pos    = '0;
    name_phase  = PH_BASE;
    dot_pending = 1'b0;
  endfunction

  function automatic bit finish_name(input logic sep, output result_t r);
    r = '0;
    for (int i = 0; i < BASE_BYTES; i++) r.name_base = {r.name_base[55:0], name_buf[i]};
    for (int i = 0; i < EXT_BYTES; i++) r.name_ext = {r.name_ext[15:0], name_buf[BASE_BYTES + i]};
    r.status             = STAT_OK;
    r.ended_by_separator = sep;
    restart_name();
    return 1'b1;
  endfunction

  function automatic bit fail_name(input status_t s, output result_t r);
    r           = '0;
    r.status    = s;
    name_phase  = PH_SKIP;
    dot_pending = 1'b0;
    return 1'b1;
  endfunction

  function automatic void enter_ext();
    name_phase  = PH_EXT;
    name_pos    = '0;
    dot_pending = 1'b0;
  endfunction

  function automatic bit ext_byte(input class_t k, output result_t r);
    r = '0;
    if (k.kind == K_TERM) return finish_name(k.sep, r);
    if (k.kind == K_ILLEGAL) return fail_name(STAT_ILLEGAL, r);
    if (k.kind == K_DOT || name_pos >= EXT_BYTES) return fail_name(STAT_EXT_BAD, r);
    name_buf[BASE_BYTES + name_pos] = k.ch;
    name_pos++;
    return 1'b0;
  endfunction

  // advances the name state by one path byte, returns 1 when a result is due
  function automatic bit predict_name(input logic [7:0] c, output result_t r);
    class_t k;
    bit     got;
    k   = classify_byte(c);
    got = 1'b0;
    r   = '0;
    case (name_phase)
      PH_BASE: begin
        if (dot_pending) begin
          if (k.kind == K_TERM) begin
            name_buf[1] = CHAR_DOT;
            got = finish_name(k.sep, r);
          end else begin
            enter_ext();
            got = ext_byte(k, r);
          end
        end else if (k.kind == K_TERM) begin
          got = finish_name(k.sep, r);
        end else if (k.kind == K_DOT) begin
          if (name_pos == 0) begin
            name_buf[0] = CHAR_DOT;
            name_pos    = 4'd1;
          end else if (name_pos == 1 && name_buf[0] == CHAR_DOT) begin
            dot_pending = 1'b1;
          end else begin
            enter_ext();
          end
        end else if (name_pos >= BASE_BYTES) begin
          // a ninth byte other than a dot or terminator is dropped whatever it is
          name_phase = PH_EXTRA;
        end else if (k.kind == K_ILLEGAL) begin
          got = fail_name(STAT_ILLEGAL, r);
        end else begin
          name_buf[name_pos] = k.ch;
          name_pos++;
        end
      end
      PH_EXTRA: begin
        if (k.kind == K_TERM) got = finish_name(k.sep, r);
        else if (k.kind == K_DOT) enter_ext();
        else if (k.kind == K_ILLEGAL) got = fail_name(STAT_ILLEGAL, r);
        else got = fail_name(STAT_BASE_LEN, r);
      end
      PH_EXT: got = ext_byte(k, r);
      default: begin
        if (k.kind == K_TERM) restart_name();
      end
    endcase
    return got;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic void queue_byte(input logic [7:0] c);
    pending_chars.push_back(c);
    queued_chars++;
  endfunction

  function automatic logic [7:0] legal_byte();
    logic [7:0] c;
    class_t     k;
    case ($urandom_range(0, 5))
      0: c = 8'("A" + $urandom_range(0, 25));
      1: c = 8'("a" + $urandom_range(0, 25));
      2: c = 8'("0" + $urandom_range(0, 9));
      3: begin
        do begin
          c = 8'($urandom_range(32, 126));
          k = classify_byte(c);
        end while (k.kind != K_CHAR);
      end
      4: c = 8'($urandom_range(128, 255));
      default: c = CHAR_DELETED;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] illegal_byte();
    logic [7:0] c;
    class_t     k;
    do begin
      c = 8'($urandom_range(1, 127));
      k = classify_byte(c);
    end while (k.kind != K_ILLEGAL);
    return c;
  endfunction

  function automatic logic [7:0] term_byte();
    case ($urandom_range(0, 2))
      0: return CHAR_NUL;
      1: return CHAR_SLASH;
      default: return CHAR_BSLASH;
    endcase
  endfunction

  function automatic void queue_component();
    int unsigned shape;
    int unsigned blen;
    int unsigned elen;
    int unsigned pick;
    shape = $urandom_range(0, 99);
    if (shape < 60) begin
      // well-formed name, sometimes at or past the length limits
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
      for (int i = 0; i < blen; i++) queue_byte(legal_byte());
      if ($urandom_range(0, 2) != 0) begin
        queue_byte(CHAR_DOT);
        elen = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(0, 3);
        for (int i = 0; i < elen; i++) queue_byte(legal_byte());
      end
    end else if (shape < 75) begin
      // leading dot forms
      queue_byte(CHAR_DOT);
      if ($urandom_range(0, 1) != 0) queue_byte(CHAR_DOT);
      blen = $urandom_range(0, 2);
      for (int i = 0; i < blen; i++) begin
        pick = $urandom_range(0, 9);
        queue_byte(pick < 7 ? legal_byte() : (pick < 9 ? CHAR_DOT : illegal_byte()));
      end
    end else if (shape < 90) begin
      // mostly legal bytes with stray dots and illegal bytes
      blen = $urandom_range(1, 13);
      for (int i = 0; i < blen; i++) begin
        pick = $urandom_range(0, 9);
        queue_byte(pick < 8 ? legal_byte() : (pick < 9 ? CHAR_DOT : illegal_byte()));
      end
    end else begin
      blen = $urandom_range(0, 12);
      for (int i = 0; i < blen; i++) queue_byte(8'($urandom_range(0, 255)));
    end
    queue_byte(term_byte());
  endfunction

  // ---------------- clock, reset, stimulus ----------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.path_char  = '0;
    out_chan.ready     = 1'b0;
    queued_chars       = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    failed             = 1'b0;
    restart_name();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // dotdot, dot, empty component
    queue_byte(CHAR_DOT); queue_byte(CHAR_DOT); queue_byte(CHAR_NUL);
    queue_byte(CHAR_DOT); queue_byte(CHAR_BSLASH);
    queue_byte(CHAR_SLASH);
    // deleted marker, high byte, lower case, extension
    queue_byte(CHAR_DELETED); queue_byte(8'hFF); queue_byte("z");
    queue_byte(CHAR_DOT); queue_byte("~"); queue_byte(CHAR_SLASH);
    // illegal byte, then skipping up to the terminator
    queue_byte("*"); queue_byte("a"); queue_byte(CHAR_SLASH);
    // dropped ninth byte, tenth byte gives base too long
    for (int i = 0; i < 10; i++) queue_byte(8'("0" + (i + 1) % 10));
    queue_byte(CHAR_NUL);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 80; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 80; end
        default: begin send_idle_pct <= 32; recv_stall_pct <= 32; end
      endcase
      while (queued_chars < (ph + 1) * PATH_BYTES / 4) queue_component();
      while (pending_chars.size() != 0) @(posedge clk);
    end

    while (in_chan.valid || expected_names.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failed) begin
      $display("CHECKS FAILED");
    end else begin
      $display("ALL CHECKS PASSED");
    end
    $finish;
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        if (predict_name(in_chan.path_char, name_got)) expected_names.push_back(name_got);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_chan.valid     <= 1'b1;
          in_chan.path_char <= pending_chars.pop_front();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_names.size() == 0) begin
        $error("unexpected name: base %h ext %h status %0d", out_chan.name_base,
               out_chan.name_ext, out_chan.status);
        failed <= 1'b1;
      end else begin
        want = expected_names.pop_front();
        if (out_chan.name_base !== want.name_base) begin
          $error("name_base: expected %h, actual %h", want.name_base, out_chan.name_base);
          failed <= 1'b1;
        end
        if (out_chan.name_ext !== want.name_ext) begin
          $error("name_ext: expected %h, actual %h", want.name_ext, out_chan.name_ext);
          failed <= 1'b1;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          failed <= 1'b1;
        end
        if (out_chan.ended_by_separator !== want.ended_by_separator) begin
          $error("ended_by_separator: expected %0d, actual %0d", want.ended_by_separator,
                 out_chan.ended_by_separator);
          failed <= 1'b1;
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire

[sim.f]
hdl/fsnp_pkg.sv
hdl/fsnp_if.sv
hdl/fsnp_classify.sv
hdl/fsnp_core.sv
hdl/fat_short_name_parser_unit.sv
tb/fat_short_name_parser_unit_tb.sv
